// ===== hw/rtl/wsl_pkg.sv =====
package wsl_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_FILE_HDR  = 3'd0,
      PH_CHUNK_HDR = 3'd1,
      PH_SKIP      = 3'd2,
      PH_PAYLOAD   = 3'd3,
      PH_DONE      = 3'd4
   } phase_type;

   // Tags as little-endian words (first byte in bits 7:0)
   localparam logic [31:0] RIFF_LE     = 32'h4646_4952;
   localparam logic [31:0] WAVE_LE     = 32'h4556_4157;
   localparam logic [31:0] SMPL_TAG_LE = 32'h6C70_6D73;

   localparam logic [31:0] SMPL_MIN_LEN = 32'd60;
   localparam logic [31:0] END_LIMIT    = 32'h7FFF_FFFE;

   // Byte positions within the file header, chunk header and smpl payload
   localparam logic [5:0] HDR_LAST         = 6'd11;
   localparam logic [5:0] WAVE_FIRST       = 6'd8;
   localparam logic [5:0] RIFF_LAST        = 6'd3;
   localparam logic [5:0] CHUNK_HDR_LAST   = 6'd7;
   localparam logic [5:0] TAG_LAST         = 6'd3;
   localparam logic [5:0] LOOP_COUNT_FIRST = 6'd28;
   localparam logic [5:0] LOOP_COUNT_LAST  = 6'd31;
   localparam logic [5:0] START_FIRST      = 6'd44;
   localparam logic [5:0] START_LAST       = 6'd47;
   localparam logic [5:0] END_FIRST        = 6'd48;
   localparam logic [5:0] END_LAST         = 6'd51;
   localparam logic [5:0] PAYLOAD_LAST     = 6'd59;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_item_type;

   typedef struct packed {
      logic        found;
      logic [30:0] loop_start;
      logic [30:0] loop_end_excl;
   } rsp_item_type;

   // Core result for the item at the head of the input register
   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } parse_out_type;

   // Header bytes that are compared: "RIFF" at 0-3, "WAVE" at 8-11
   function automatic logic hdr_checked(input logic [5:0] idx);
      return (idx <= RIFF_LAST) || ((idx >= WAVE_FIRST) && (idx <= HDR_LAST));
   endfunction

   function automatic logic [7:0] hdr_expect(input logic [5:0] idx);
      logic [31:0] word;
      word = idx[3] ? WAVE_LE : RIFF_LE;
      return word[{idx[1:0], 3'b000} +: 8];
   endfunction

endpackage

// ===== hw/rtl/wsl_req_if.sv =====
interface wsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/wsl_rsp_if.sv =====
interface wsl_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [30:0] loop_start;
   logic [30:0] loop_end_excl;

   modport source (output valid, output found, output loop_start, output loop_end_excl,
                   input ready);
   modport sink   (input valid, input found, input loop_start, input loop_end_excl,
                   output ready);
endinterface

// ===== hw/rtl/wsl_in_stage.sv =====
module wsl_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   wsl_req_if.sink              req,
   input  logic                 take,
   output logic                 valid,
   output wsl_pkg::in_item_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   wsl_pkg::in_item_type item_ff;
   logic                 xfer;

   // Room whenever empty or the held byte is consumed this cycle
   assign req.ready = !valid_ff || take;
   assign xfer      = req.valid && req.ready;

   always_comb begin
      priority if (xfer) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (xfer) begin
         item_ff.data_byte <= req.data_byte;
         item_ff.last_byte <= req.last_byte;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

// ===== hw/rtl/wsl_parse_core.sv =====
module wsl_parse_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  wsl_pkg::in_item_type   item,
   output wsl_pkg::parse_out_type pout
);

   wsl_pkg::phase_type phase_ff, phase_in;
   logic [5:0]         byte_index_ff, byte_index_in;
   logic               header_ok_ff, header_ok_in;
   logic [31:0]        chunk_tag_ff, chunk_tag_in;
   logic [31:0]        chunk_length_ff, chunk_length_in;
   logic [32:0]        skip_remaining_ff, skip_remaining_in;
   logic               has_loop_ff, has_loop_in;
   logic [31:0]        start_word_ff, start_word_in;
   logic [31:0]        end_word_ff, end_word_in;

   logic               decided;
   logic               found;
   logic               hdr_ok_now;
   logic [4:0]         lane;

   assign lane = {byte_index_ff[1:0], 3'b000};

   // Next state and result for the byte in the input register
   always_comb begin
      phase_in          = phase_ff;
      byte_index_in     = byte_index_ff;
      header_ok_in      = header_ok_ff;
      chunk_tag_in      = chunk_tag_ff;
      chunk_length_in   = chunk_length_ff;
      skip_remaining_in = skip_remaining_ff;
      has_loop_in       = has_loop_ff;
      start_word_in     = start_word_ff;
      end_word_in       = end_word_ff;
      decided           = 1'b0;
      found             = 1'b0;
      hdr_ok_now        = header_ok_ff;

      unique case (phase_ff)
         wsl_pkg::PH_FILE_HDR: begin
            if (wsl_pkg::hdr_checked(byte_index_ff) &&
                (item.data_byte != wsl_pkg::hdr_expect(byte_index_ff))) begin
               hdr_ok_now = 1'b0;
            end
            header_ok_in = hdr_ok_now;
            if (byte_index_ff >= wsl_pkg::HDR_LAST) begin
               byte_index_in = '0;
               if (hdr_ok_now) begin
                  phase_in = wsl_pkg::PH_CHUNK_HDR;
               end else begin
                  phase_in = wsl_pkg::PH_DONE;
                  decided  = 1'b1;
               end
            end else begin
               byte_index_in = byte_index_ff + 6'd1;
            end
         end

         wsl_pkg::PH_CHUNK_HDR: begin
            if (byte_index_ff <= wsl_pkg::TAG_LAST) begin
               chunk_tag_in[lane +: 8] = item.data_byte;
            end else begin
               chunk_length_in[lane +: 8] = item.data_byte;
            end
            if (byte_index_ff >= wsl_pkg::CHUNK_HDR_LAST) begin
               byte_index_in = '0;
               if ((chunk_tag_ff == wsl_pkg::SMPL_TAG_LE) &&
                   (chunk_length_in >= wsl_pkg::SMPL_MIN_LEN)) begin
                  phase_in    = wsl_pkg::PH_PAYLOAD;
                  has_loop_in = 1'b0;
               end else begin
                  // odd sizes carry one pad byte
                  skip_remaining_in = {1'b0, chunk_length_in} + {32'd0, chunk_length_in[0]};
                  phase_in = (skip_remaining_in == '0) ? wsl_pkg::PH_CHUNK_HDR
                                                       : wsl_pkg::PH_SKIP;
               end
            end else begin
               byte_index_in = byte_index_ff + 6'd1;
            end
         end

         wsl_pkg::PH_SKIP: begin
            if (skip_remaining_ff != '0) begin
               skip_remaining_in = skip_remaining_ff - 33'd1;
            end
            if (skip_remaining_in == '0) begin
               phase_in      = wsl_pkg::PH_CHUNK_HDR;
               byte_index_in = '0;
            end
         end

         wsl_pkg::PH_PAYLOAD: begin
            if ((byte_index_ff >= wsl_pkg::LOOP_COUNT_FIRST) &&
                (byte_index_ff <= wsl_pkg::LOOP_COUNT_LAST) && (item.data_byte != 8'd0)) begin
               has_loop_in = 1'b1;
            end
            if ((byte_index_ff >= wsl_pkg::START_FIRST) &&
                (byte_index_ff <= wsl_pkg::START_LAST)) begin
               start_word_in[lane +: 8] = item.data_byte;
            end
            if ((byte_index_ff >= wsl_pkg::END_FIRST) &&
                (byte_index_ff <= wsl_pkg::END_LAST)) begin
               end_word_in[lane +: 8] = item.data_byte;
            end
            if (byte_index_ff >= wsl_pkg::PAYLOAD_LAST) begin
               // loop words are complete well before the last payload byte
               found = has_loop_ff && (end_word_ff >= start_word_ff) &&
                       (end_word_ff < wsl_pkg::END_LIMIT);
               decided       = 1'b1;
               phase_in      = wsl_pkg::PH_DONE;
               byte_index_in = '0;
            end else begin
               byte_index_in = byte_index_ff + 6'd1;
            end
         end

         wsl_pkg::PH_DONE: begin
            // rest of the file is dropped
         end

         default: begin
            phase_in = wsl_pkg::PH_DONE;
         end
      endcase

      pout.emit = decided || (item.last_byte && (phase_ff != wsl_pkg::PH_DONE));
      pout.item.found         = found;
      pout.item.loop_start    = found ? start_word_ff[30:0] : '0;
      pout.item.loop_end_excl = found ? (end_word_ff[30:0] + 31'd1) : '0;

      // Rearm for the next file after its last byte
      if (item.last_byte) begin
         phase_in          = wsl_pkg::PH_FILE_HDR;
         byte_index_in     = '0;
         header_ok_in      = 1'b1;
         skip_remaining_in = '0;
         has_loop_in       = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= wsl_pkg::PH_FILE_HDR;
         byte_index_ff     <= '0;
         header_ok_ff      <= 1'b1;
         skip_remaining_ff <= '0;
         has_loop_ff       <= 1'b0;
      end else if (step) begin
         phase_ff          <= phase_in;
         byte_index_ff     <= byte_index_in;
         header_ok_ff      <= header_ok_in;
         skip_remaining_ff <= skip_remaining_in;
         has_loop_ff       <= has_loop_in;
      end
   end

   // Assembled words, always fully written before use
   always_ff @(posedge clock) begin
      if (step) begin
         chunk_tag_ff    <= chunk_tag_in;
         chunk_length_ff <= chunk_length_in;
         start_word_ff   <= start_word_in;
         end_word_ff     <= end_word_in;
      end
   end

endmodule

// ===== hw/rtl/wsl_rsp_stage.sv =====
module wsl_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   wsl_rsp_if.source             rsp,
   input  logic                  load,
   input  wsl_pkg::rsp_item_type item,
   output logic                  free
);

   logic                  valid_ff;
   logic                  valid_in;
   wsl_pkg::rsp_item_type item_ff;

   // Slot can be refilled when empty or drained this cycle
   assign free = !valid_ff || rsp.ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.found         = item_ff.found;
   assign rsp.loop_start    = item_ff.loop_start;
   assign rsp.loop_end_excl = item_ff.loop_end_excl;

endmodule

// ===== hw/rtl/wav_smpl_loop_parser_unit.sv =====
// Channel  Dir  Payload                                 Transfer
// -------  ---  --------------------------------------  -------------------
// req      in   data_byte[7:0], last_byte               req.valid & req.ready
// rsp      out  found, loop_start[30:0],                rsp.valid & rsp.ready
//               loop_end_excl[30:0]
//
// One byte per clock cycle unless the input register stalls; a byte's result moves
// from the input register into the result register. The parser state and the loop
// decision sit in one level of logic between the two registers.
// Reset is synchronous; there is no clearing pass, the parser is ready right after.
// The input register stalls only when its byte produces a result while the result
// register is full and not being taken; bytes that produce no result keep flowing.
module wav_smpl_loop_parser_unit (
   input logic       clock,
   input logic       reset,
   wsl_req_if.sink   req,
   wsl_rsp_if.source rsp
);

   logic                   in_valid;
   wsl_pkg::in_item_type   in_item;
   wsl_pkg::parse_out_type pout;
   logic                   rsp_free;
   logic                   take;
   logic                   load;

   // Consume the held byte unless its result has nowhere to go
   assign take = in_valid && (!pout.emit || rsp_free);
   assign load = take && pout.emit;

   wsl_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .take  (take),
      .valid (in_valid),
      .item  (in_item)
   );

   wsl_parse_core u_parse_core (
      .clock (clock),
      .reset (reset),
      .step  (take),
      .item  (in_item),
      .pout  (pout)
   );

   wsl_rsp_stage u_rsp_stage (
      .clock (clock),
      .reset (reset),
      .rsp   (rsp),
      .load  (load),
      .item  (pout.item),
      .free  (rsp_free)
   );

   // A new result never lands on one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp.valid || rsp.ready))
      else $error("result register overwritten");

   // A found loop is never empty
   a_found_order: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.found) |-> (rsp.loop_end_excl > rsp.loop_start))
      else $error("found loop with end not above start");

   // Not-found results carry zero fields
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.found) |-> ((rsp.loop_start == '0) && (rsp.loop_end_excl == '0)))
      else $error("not-found result with nonzero fields");

   // An empty input register always takes a byte
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid |-> req.ready)
      else $error("input stalled while empty");

endmodule
